/* rtl/core/http_chunked_body_decoder_top_assert.svh */
// Assertion macros for the chunked body decoder.
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define HCBD_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HCBD_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/hcbd_pkg.sv */
`default_nettype none
package hcbd_pkg;

  localparam int SIZE_BITS_DEF = 32;
  localparam int COUNT_W       = 32;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_SP  = 8'd32;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_VT  = 8'd11;
  localparam logic [7:0] CH_FF  = 8'd12;

  localparam logic REG_CHUNKED_ENABLE = 1'b0;

  typedef enum logic [5:0] {
    PH_SIZE = 6'b000001,
    PH_DATA = 6'b000010,
    PH_CR   = 6'b000100,
    PH_LF   = 6'b001000,
    PH_DONE = 6'b010000,
    PH_ERR  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.valid = 1'b1;
    h.nib   = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.nib = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.nib = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.nib = 4'(b - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/http_chunked_body_decoder_top.sv */
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// input    | in_valid / in_ready  | in_byte
// result   | res_valid / res_ready| out_byte out_valid done_res error body_count
// config   | APB psel/penable     | paddr pwdata prdata (chunked_enable at 0x0)
//
// One byte per clock while results are taken (input register, result register).
// Each byte is decoded by the single-pass logic between the two registers.
// A stalled result holds; one more byte can wait in the input register.
// Synchronous active-high reset puts the parser at the start of a size line.
`default_nettype none
module http_chunked_body_decoder_top import hcbd_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_byte,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output logic [7:0]               out_byte,
  output logic                     out_valid,
  output logic                     done_res,
  output logic                     error,
  output logic [COUNT_W-1:0]       body_count,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  logic                 chunked_enable;
  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 advance;

  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] size_accum, size_accum_next;
  logic [SIZE_BITS-1:0] bytes_left, bytes_left_next, bytes_dec;
  logic                 digit_seen, digit_seen_next;
  logic                 digits_ended, digits_ended_next;
  logic                 prev_was_cr, prev_was_cr_next;
  logic                 line_nonempty, line_nonempty_next;
  logic [COUNT_W-1:0]   payload_total, payload_total_next;
  logic                 fwd;
  hex_t                 hv;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_CHUNKED_ENABLE) ?
                  {{(DATA_W-1){1'b0}}, chunked_enable} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunked_enable <= 1'b0;
    end else if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_CHUNKED_ENABLE) begin
      chunked_enable <= pwdata[0];
    end
  end

  // handshake
  assign advance  = s1_valid && (!res_valid || res_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
    end
  end

  // decode
  assign hv        = hex_decode(s1_byte);
  assign bytes_dec = bytes_left - SIZE_BITS'(1);

  always_comb begin
    phase_next         = phase;
    size_accum_next    = size_accum;
    bytes_left_next    = bytes_left;
    digit_seen_next    = digit_seen;
    digits_ended_next  = digits_ended;
    prev_was_cr_next   = prev_was_cr;
    line_nonempty_next = line_nonempty;
    fwd                = 1'b0;
    if (!chunked_enable) begin
      fwd = 1'b1;
    end else begin
      case (phase)
        PH_SIZE: begin
          if (s1_byte == CH_LF) begin
            if (!prev_was_cr || !digit_seen || size_accum == '1) begin
              phase_next = PH_ERR;
            end else if (size_accum == '0) begin
              phase_next = PH_DONE;
            end else begin
              bytes_left_next = size_accum;
              phase_next      = PH_DATA;
            end
            size_accum_next    = '0;
            digit_seen_next    = 1'b0;
            digits_ended_next  = 1'b0;
            prev_was_cr_next   = 1'b0;
            line_nonempty_next = 1'b0;
          end else begin
            if (line_nonempty || !is_blank(s1_byte)) begin
              line_nonempty_next = 1'b1;
              if (!digits_ended && hv.valid) begin
                if (|size_accum[SIZE_BITS-1 -: 4]) begin
                  size_accum_next = '1;
                end else begin
                  size_accum_next = {size_accum[SIZE_BITS-5:0], hv.nib};
                end
                digit_seen_next = 1'b1;
              end else begin
                digits_ended_next = 1'b1;
              end
            end
            prev_was_cr_next = (s1_byte == CH_CR);
          end
        end
        PH_DATA: begin
          fwd             = 1'b1;
          bytes_left_next = bytes_dec;
          if (bytes_dec == '0) begin
            phase_next = PH_CR;
          end
        end
        PH_CR: begin
          phase_next = (s1_byte == CH_CR) ? PH_LF : PH_ERR;
        end
        PH_LF: begin
          phase_next = (s1_byte == CH_LF) ? PH_SIZE : PH_ERR;
        end
        default: begin
        end
      endcase
    end
    payload_total_next = (fwd && payload_total != '1) ? payload_total + COUNT_W'(1)
                                                      : payload_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIZE;
      size_accum    <= '0;
      bytes_left    <= '0;
      digit_seen    <= 1'b0;
      digits_ended  <= 1'b0;
      prev_was_cr   <= 1'b0;
      line_nonempty <= 1'b0;
      payload_total <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      size_accum    <= size_accum_next;
      bytes_left    <= bytes_left_next;
      digit_seen    <= digit_seen_next;
      digits_ended  <= digits_ended_next;
      prev_was_cr   <= prev_was_cr_next;
      line_nonempty <= line_nonempty_next;
      payload_total <= payload_total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte   <= fwd ? s1_byte : 8'd0;
      out_valid  <= fwd;
      done_res   <= (phase_next == PH_DONE);
      error      <= (phase_next == PH_ERR);
      body_count <= payload_total_next;
    end
  end

  `include "http_chunked_body_decoder_top_assert.svh"

  `HCBD_ASSERT_NOW(a_phase_onehot, 1'b1, $onehot(phase), "phase not one-hot")
  `HCBD_ASSERT_NEXT(a_data_fwd, advance && chunked_enable && phase == PH_DATA,
                    res_valid && out_valid, "payload byte not forwarded")
  `HCBD_ASSERT_NEXT(a_count_mono, advance,
                    body_count >= $past(payload_total), "body count went backward")

endmodule
`default_nettype wire

/* test/tb_http_chunked_body_decoder_top.sv */
`timescale 1ns / 100ps
module tb_http_chunked_body_decoder_top;
  import hcbd_pkg::*;

  localparam int SZW = SIZE_BITS_DEF;
  localparam logic [SZW-1:0] SIZE_TOP = '1;
  localparam logic [ADDR_W-1:0] ENABLE_ADDR = ADDR_W'(4 * int'(REG_CHUNKED_ENABLE));
  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 120;

  typedef enum int {
    END_ZERO, END_NO_DIGITS, END_OVF_EXACT, END_OVF_SAT, END_BAD_CR, END_BAD_LF, END_BARE_LF
  } end_kind_t;

  typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_PATTERN, RDY_SPARSE} ready_mode_t;

  typedef struct packed {
    logic [7:0]         data;
    logic               fwd;
    logic               done;
    logic               err;
    logic [COUNT_W-1:0] count;
  } body_rsp_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_byte = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic [7:0]         out_byte;
  logic               out_valid;
  logic               done_res;
  logic               error;
  logic [COUNT_W-1:0] body_count;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  http_chunked_body_decoder_top u_top (
    .clk, .rst, .in_valid, .in_ready, .in_byte, .res_valid, .res_ready,
    .out_byte, .out_valid, .done_res, .error, .body_count,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // decoder mirror
  logic               chunk_en = 1'b0;
  phase_t             st_phase = PH_SIZE;
  logic [SZW-1:0]     st_acc = '0;
  logic [SZW-1:0]     st_left = '0;
  logic [COUNT_W-1:0] st_total = '0;
  logic               st_digit = 1'b0;
  logic               st_dig_end = 1'b0;
  logic               st_cr = 1'b0;
  logic               st_started = 1'b0;

  body_rsp_t   pending_q[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned passthru_bytes = 0;
  int unsigned chunks_sent = 0;
  int unsigned mode_writes = 0;
  int unsigned burst_left = 0;
  int unsigned cyc = 0;
  int unsigned hold_asks = 0;
  int unsigned holds_begun = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  ready_mode_t rdy_mode = RDY_ALWAYS;
  end_kind_t   end_kind = END_ZERO;
  logic [7:0]  blank_set [5] = '{CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR};

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc, pending_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("MISMATCH @%0t %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic predict_byte(input logic [7:0] b);
    body_rsp_t  r;
    logic       fwd;
    logic       is_hex;
    logic [3:0] nib;
    fwd = 1'b0;
    is_hex = 1'b1;
    nib = '0;
    if (b >= "0" && b <= "9") nib = 4'(b - "0");
    else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 8'd10);
    else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 8'd10);
    else is_hex = 1'b0;
    if (!chunk_en) begin
      fwd = 1'b1;
      passthru_bytes++;
    end else begin
      case (st_phase)
        PH_SIZE: begin
          if (b == CH_LF) begin
            if (!st_cr || !st_digit || st_acc == SIZE_TOP) st_phase = PH_ERR;
            else if (st_acc == '0) st_phase = PH_DONE;
            else begin
              st_left = st_acc;
              st_phase = PH_DATA;
            end
            st_acc = '0;
            st_digit = 1'b0;
            st_dig_end = 1'b0;
            st_cr = 1'b0;
            st_started = 1'b0;
          end else begin
            if (st_started || !((b == CH_SP) || (b == CH_TAB) || (b == CH_VT) ||
                                 (b == CH_FF) || (b == CH_CR))) begin
              st_started = 1'b1;
              if (!st_dig_end && is_hex) begin
                if (st_acc[SZW-1 -: 4] != 4'd0) st_acc = SIZE_TOP;
                else st_acc = {st_acc[SZW-5:0], nib};
                st_digit = 1'b1;
              end else begin
                st_dig_end = 1'b1;
              end
            end
            st_cr = (b == CH_CR);
          end
        end
        PH_DATA: begin
          fwd = 1'b1;
          st_left = st_left - 1'b1;
          if (st_left == '0) st_phase = PH_CR;
        end
        PH_CR: st_phase = (b == CH_CR) ? PH_LF : PH_ERR;
        PH_LF: st_phase = (b == CH_LF) ? PH_SIZE : PH_ERR;
        default: ;
      endcase
    end
    if (fwd && st_total != '1) st_total = st_total + 1'b1;
    r.data = fwd ? b : 8'd0;
    r.fwd = fwd;
    r.done = (st_phase == PH_DONE);
    r.err = (st_phase == PH_ERR);
    r.count = st_total;
    pending_q.push_back(r);
  endtask

  always @(posedge clk) begin
    body_rsp_t want;
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        flag_mismatch("result with nothing expected, out_byte", out_byte, 0);
      end else begin
        want = pending_q.pop_front();
        if (out_byte !== want.data) flag_mismatch("out_byte", out_byte, want.data);
        if (out_valid !== want.fwd) flag_mismatch("out_valid", out_valid, want.fwd);
        if (done_res !== want.done) flag_mismatch("done_res", done_res, want.done);
        if (error !== want.err) flag_mismatch("error", error, want.err);
        if (body_count !== want.count) flag_mismatch("body_count", body_count, want.count);
      end
    end
  end

  // result side: long hold on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (holds_begun != hold_asks) begin
      holds_begun <= hold_asks;
      hold_left <= LONG_HOLD;
      res_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rdy_mode <= ready_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rdy_mode)
        RDY_ALWAYS:  res_ready <= 1'b1;
        RDY_MOSTLY:  res_ready <= ($urandom_range(0, 3) != 0);
        RDY_PATTERN: res_ready <= ((cyc % 7) < 3);
        default:     res_ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    predict_byte(b);
    items_sent++;
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_enable(input logic en);
    logic [DATA_W-1:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ENABLE_ADDR;
    pwdata <= DATA_W'(en);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    chunk_en = en;
    mode_writes++;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== DATA_W'(en)) flag_mismatch("chunked_enable readback", rd, en);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 16);
    if (r < 19) return $urandom_range(17, 64);
    return $urandom_range(100, 300);
  endfunction

  task automatic send_size_line(input logic [SZW-1:0] size, input bit decorate);
    int         nd;
    logic [7:0] ext;
    nd = 1;
    for (int i = 1; i < SZW / 4; i++) if (size[4*i +: 4] != 4'd0) nd = i + 1;
    if (decorate) begin
      repeat ($urandom_range(0, 3)) push_byte(blank_set[$urandom_range(0, 4)]);
      repeat ($urandom_range(0, 2)) push_byte("0");
    end
    for (int i = nd - 1; i >= 0; i--) push_byte(hex_char(size[4*i +: 4], $urandom_range(0, 1)));
    if (decorate && $urandom_range(0, 2) == 0) begin
      push_byte($urandom_range(0, 1) ? ";" : " ");
      repeat ($urandom_range(0, 5)) begin
        ext = 8'($urandom);
        if (ext == CH_LF) ext = CH_CR;
        push_byte(ext);
      end
    end
    push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  task automatic send_chunk(input int unsigned size, input bit decorate);
    send_size_line(SZW'(size), decorate);
    repeat (size) push_byte(8'($urandom));
    push_byte(CH_CR);
    push_byte(CH_LF);
    chunks_sent++;
  endtask

  task automatic test_passthrough();
    write_enable(1'b0);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte("0");
    push_byte("a");
    settle_idle();
  endtask

  task automatic test_framing();
    write_enable(1'b1);
    // every blank kind ahead of the digits
    push_byte(CH_SP);
    push_byte(CH_TAB);
    push_byte(CH_VT);
    push_byte(CH_FF);
    push_byte(CH_CR);
    push_byte("2");
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_CR);
    push_byte(CH_LF);
    // leading zero, hex after a blank ignored, stray CR inside the line
    push_byte("0");
    push_byte("1");
    push_byte(" ");
    push_byte("A");
    push_byte("b");
    push_byte(";");
    push_byte(CH_CR);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(CH_LF);
    push_byte(CH_CR);
    push_byte(CH_LF);
    chunks_sent += 2;
  endtask

  task automatic test_mode_switch();
    // drop to pass-through in the middle of a payload
    send_size_line(SZW'(5), 1'b0);
    push_byte(8'($urandom));
    push_byte(8'($urandom));
    settle_idle();
    write_enable(1'b0);
    repeat (6) push_byte(8'($urandom));
    settle_idle();
    write_enable(1'b1);
    repeat (3) push_byte(8'($urandom));
    push_byte(CH_CR);
    push_byte(CH_LF);
    chunks_sent++;
    // and between chunks
    settle_idle();
    write_enable(1'b0);
    repeat (4) push_byte(8'($urandom));
    settle_idle();
    write_enable(1'b1);
    send_chunk(pick_size(), 1'b1);
  endtask

  task automatic test_backpressure();
    hold_asks++;
    send_chunk(48, 1'b0);
    settle_idle();
  endtask

  task automatic test_random_chunks();
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 15))
        0: begin
          settle_idle();
          write_enable(1'b0);
          repeat ($urandom_range(1, 12)) push_byte(8'($urandom));
          settle_idle();
          write_enable(1'b1);
        end
        1: settle_idle();
        default: send_chunk(pick_size(), $urandom_range(0, 1));
      endcase
    end
  endtask

  task automatic test_termination();
    end_kind = end_kind_t'($urandom_range(0, 6));
    case (end_kind)
      END_ZERO: send_size_line('0, 1'b1);
      END_NO_DIGITS: begin
        push_byte(";");
        push_byte("x");
        push_byte(CH_CR);
        push_byte(CH_LF);
      end
      END_OVF_EXACT: send_size_line(SIZE_TOP, 1'b0);
      END_OVF_SAT: begin
        push_byte("1");
        repeat (SZW / 4) push_byte("0");
        push_byte(CH_CR);
        push_byte(CH_LF);
      end
      END_BAD_CR: begin
        send_size_line(SZW'(2), 1'b0);
        repeat (2) push_byte(8'($urandom));
        push_byte("X");
      end
      END_BAD_LF: begin
        send_size_line(SZW'(1), 1'b0);
        push_byte(8'($urandom));
        push_byte(CH_CR);
        push_byte(CH_CR);
      end
      default: begin
        push_byte("4");
        push_byte(CH_LF);
      end
    endcase
    // flags stay, bytes dropped; pass-through still works afterwards
    repeat (20) push_byte(8'($urandom));
    settle_idle();
    write_enable(1'b0);
    repeat (8) push_byte(8'($urandom));
    settle_idle();
    write_enable(1'b1);
    repeat (6) push_byte(8'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_passthrough();
    test_framing();
    test_mode_switch();
    test_backpressure();
    test_random_chunks();
    test_termination();
    settle_idle();
    repeat (8) @(posedge clk);
    $display("%0d bytes sent, %0d chunks framed, %0d bytes in pass-through, %0d results checked",
             items_sent, chunks_sent, passthru_bytes, results_seen);
    $display("%0d enable writes, %0d long result holds, stream closed by %s",
             mode_writes, hold_asks, end_kind.name());
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/hcbd_pkg.sv
rtl/core/http_chunked_body_decoder_top.sv
test/tb_http_chunked_body_decoder_top.sv
